/* hdl/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg
// Shared constants and command codes of the antialiased line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 4;

    localparam int COORD_BITS = 15;
    localparam int GRAD_BITS  = 16;
    localparam int CFG_BITS   = 9;
    localparam int VAL_BITS   = 8;
    localparam int CNT_BITS   = 10;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd256;
    localparam logic [CNT_BITS-1:0] CNT_LIMIT = 10'd1023;
    localparam logic [VAL_BITS-1:0] FULL_GREY = 8'd255;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_POINT = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_index;

endpackage

/* hdl/antialiased_line_raster_top.sv */
// ----------------------------------------------------------------------------
// antialiased_line_raster_top
// Antialiased line rasterizer with a greyscale frame store in one memory.
//
//   channel   | handshake          | payload
//   command   | i_start / o_busy   | i_operation, i_start_x/y, i_end_x/y
//   result    | o_valid (strobe)   | o_read_value, o_pixels_touched
//   config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A line first orders its endpoints, then runs a serial divide for the gradient
// (skipped when the endpoints share a column), then draws both endpoint columns
// and then the inner columns: each pixel is a read-modify-write, and the memory
// access is skipped when the pixel is off frame. Point and read pass the same
// level and address steps before their access; a clear sweeps every address.
// After reset the store is swept to black with o_busy high.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module antialiased_line_raster_top #(
    parameter int MAX_WIDTH  = alr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = alr_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [1:0]                          i_operation,
    input  logic signed [alr_pkg::COORD_BITS-1:0] i_start_x,
    input  logic signed [alr_pkg::COORD_BITS-1:0] i_start_y,
    input  logic signed [alr_pkg::COORD_BITS-1:0] i_end_x,
    input  logic signed [alr_pkg::COORD_BITS-1:0] i_end_y,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [alr_pkg::CFG_BITS-1:0]        i_cfg_data,
    output logic                                o_valid,
    output logic [alr_pkg::VAL_BITS-1:0]        o_read_value,
    output logic [alr_pkg::CNT_BITS-1:0]        o_pixels_touched
);

    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEP = MAX_WIDTH * MAX_HEIGHT;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = alr_pkg::COORD_BITS + 1;
    localparam int PW  = 20;
    localparam int GB  = alr_pkg::GRAD_BITS;
    localparam int GW  = GB + 2;
    localparam int YW  = 36;
    localparam int DVW = alr_pkg::COORD_BITS + GB;
    localparam int QW  = $clog2(DVW + 1);
    localparam int FW  = FRAC_BITS + 1;
    localparam int MW  = GB + 1 + FW;

    localparam logic [alr_pkg::CNT_BITS-1:0] CNT_ONE = alr_pkg::CNT_BITS'(1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PREP, S_DIV, S_END, S_LVL, S_ADR,
        S_RD, S_WR, S_RDB, S_PT, S_NEXT, S_DONE
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_clr;
    logic                        r_clr_cmd;
    logic [1:0]                  r_op;
    logic [alr_pkg::CFG_BITS-1:0] r_fw, r_fh;
    logic signed [CW-1:0]        r_x0, r_y0, r_x1, r_y1;
    logic [CW-1:0]               r_dx;
    logic                        r_dy_neg;
    logic                        r_steep;
    logic [CW:0]                 r_rem;
    logic [DVW-1:0]              r_dvd;
    logic [QW-1:0]               r_qcnt;
    logic signed [GW-1:0]        r_grad;
    logic [1:0]                  r_phase;
    logic signed [PW-1:0]        r_col, r_col1, r_col2;
    logic signed [YW-1:0]        r_y, r_intery;
    logic [FW-1:0]               r_gap;
    logic                        r_sub;
    logic signed [PW-1:0]        r_px, r_py;
    logic                        r_inf;
    logic [MW-1:0]               r_prod;
    logic [AW-1:0]               r_addr;
    logic [alr_pkg::VAL_BITS-1:0] r_lvl;
    logic [alr_pkg::VAL_BITS-1:0] r_rdata;
    logic [alr_pkg::VAL_BITS-1:0] r_rval;
    logic [alr_pkg::CNT_BITS-1:0] r_cnt;
    logic                        r_valid;

    logic [alr_pkg::VAL_BITS-1:0] mem [DEP];

    logic [WW-1:0]               aw;
    logic [HW-1:0]               ah;
    logic signed [CW-1:0]        sx, sy, ex, ey, adx, ady;
    logic                        steep;
    logic signed [CW-1:0]        a0, b0, a1, b1;
    logic signed [CW:0]          dy_full;
    logic [CW-1:0]               dy_abs;
    logic [CW:0]                 trial;
    logic                        qbit;
    logic signed [PW-1:0]        tx, ty;
    logic signed [CW-1:0]        ev_x, ev_y;
    logic signed [PW-1:0]        ecol;
    logic signed [FW:0]          cdiff;
    logic signed [GW+FW:0]       eprod;
    logic signed [YW-1:0]        yend;
    logic [FRAC_BITS-1:0]        xfr;
    logic [FW-1:0]               egap;
    logic signed [PW-1:0]        row, rowp, px, py;
    logic [GB:0]                 wgt;
    logic                        inf;
    logic [AW-1:0]               addr_full;
    logic [MW+8:0]               lvl_full;
    logic [alr_pkg::VAL_BITS-1:0] lvl;
    logic                        mem_we;
    logic [AW-1:0]               mem_wa, mem_ra;
    logic [alr_pkg::VAL_BITS-1:0] mem_wd;
    logic signed [PW-1:0]        ncol;

    function automatic logic signed [PW-1:0] round_c(input logic signed [CW-1:0] v);
        logic signed [PW-1:0] e;
        e = PW'(v);
        if (e >= 0) begin
            return (e + PW'(2 ** (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
        return -((-e + PW'(2 ** (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [PW-1:0] trunc_c(
        input logic signed [alr_pkg::COORD_BITS-1:0] v);
        logic signed [PW-1:0] e;
        e = PW'(v);
        if (e >= 0) begin
            return e >>> FRAC_BITS;
        end
        return -((-e) >>> FRAC_BITS);
    endfunction

    always_comb begin
        aw = (32'(r_fw) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(r_fw);
        ah = (32'(r_fh) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(r_fh);

        sx = CW'(i_start_x);
        sy = CW'(i_start_y);
        ex = CW'(i_end_x);
        ey = CW'(i_end_y);
        tx = trunc_c(i_start_x);
        ty = trunc_c(i_start_y);

        adx = (r_x1 >= r_x0) ? r_x1 - r_x0 : r_x0 - r_x1;
        ady = (r_y1 >= r_y0) ? r_y1 - r_y0 : r_y0 - r_y1;
        steep = ady > adx;
        a0 = steep ? r_y0 : r_x0;
        b0 = steep ? r_x0 : r_y0;
        a1 = steep ? r_y1 : r_x1;
        b1 = steep ? r_x1 : r_y1;
        if (a0 > a1) begin
            a0 = steep ? r_y1 : r_x1;
            b0 = steep ? r_x1 : r_y1;
            a1 = steep ? r_y0 : r_x0;
            b1 = steep ? r_x0 : r_y0;
        end
        dy_full = (CW + 1)'(b1) - (CW + 1)'(b0);
        dy_abs  = dy_full[CW] ? CW'(-dy_full) : CW'(dy_full);

        trial = {r_rem[CW-1:0], r_dvd[DVW-1]};
        qbit  = trial >= {1'b0, r_dx};

        ev_x  = (r_phase == 2'd0) ? r_x0 : r_x1;
        ev_y  = (r_phase == 2'd0) ? r_y0 : r_y1;
        ecol  = round_c(ev_x);
        cdiff = (FW + 1)'((ecol <<< FRAC_BITS) - PW'(ev_x));
        eprod = (GW + FW + 1)'(r_grad) * (GW + FW + 1)'(cdiff);
        yend  = (YW'(ev_y) <<< (GB - FRAC_BITS)) + YW'(eprod >>> FRAC_BITS);
        xfr   = FRAC_BITS'(ev_x + CW'(2 ** (FRAC_BITS - 1)));
        egap  = (r_phase == 2'd0) ? FW'(2 ** FRAC_BITS) - FW'(xfr) : FW'(xfr);

        row  = PW'(r_y >>> GB);
        rowp = row + PW'(r_sub);
        wgt  = r_sub ? {1'b0, r_y[GB-1:0]} : (GB + 1)'(2 ** GB) - {1'b0, r_y[GB-1:0]};
        px   = r_steep ? rowp : r_col;
        py   = r_steep ? r_col : rowp;
        inf  = !px[PW-1] && !py[PW-1]
            && ($unsigned(px) < PW'(aw)) && ($unsigned(py) < PW'(ah));

        addr_full = AW'($unsigned(r_py)) * AW'(aw) + AW'($unsigned(r_px));
        lvl_full  = ((MW + 9)'(r_prod) << 8) - (MW + 9)'(r_prod);
        lvl_full  = lvl_full >> (GB + FRAC_BITS);
        lvl = (lvl_full > (MW + 9)'(alr_pkg::FULL_GREY)) ? alr_pkg::FULL_GREY
                                                         : alr_pkg::VAL_BITS'(lvl_full);

        ncol = r_col + PW'(1);

        mem_we = (r_state == S_CLR) || (r_state == S_PT)
              || ((r_state == S_WR) && (r_rdata < r_lvl));
        mem_wa = (r_state == S_CLR) ? r_clr : r_addr;
        mem_wd = (r_state == S_CLR) ? '0
               : (r_state == S_PT) ? alr_pkg::FULL_GREY : r_lvl;
        mem_ra = r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= alr_pkg::CFG_RESET;
            r_fh <= alr_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (alr_pkg::t_cfg_index'(i_cfg_index))
                alr_pkg::CFG_WIDTH:  r_fw <= i_cfg_data;
                alr_pkg::CFG_HEIGHT: r_fh <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_cmd <= 1'b0;
            r_valid   <= 1'b0;
            r_rval    <= '0;
            r_cnt     <= '0;
            r_op      <= alr_pkg::OP_LINE;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEP - 1)) begin
                        r_state <= r_clr_cmd ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_operation;
                        r_cnt   <= '0;
                        r_rval  <= '0;
                        r_x0    <= sx;
                        r_y0    <= sy;
                        r_x1    <= ex;
                        r_y1    <= ey;
                        r_steep <= 1'b0;
                        r_sub   <= 1'b0;
                        r_col   <= tx;
                        r_y     <= YW'(ty) <<< GB;
                        r_gap   <= '0;
                        unique case (alr_pkg::t_op'(i_operation))
                            alr_pkg::OP_LINE:  r_state <= S_PREP;
                            alr_pkg::OP_POINT: r_state <= S_LVL;
                            alr_pkg::OP_READ:  r_state <= S_LVL;
                            alr_pkg::OP_CLEAR: begin
                                r_clr     <= '0;
                                r_clr_cmd <= 1'b1;
                                r_state   <= S_CLR;
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    r_steep  <= steep;
                    r_x0     <= a0;
                    r_y0     <= b0;
                    r_x1     <= a1;
                    r_y1     <= b1;
                    r_dx     <= a1 - a0;
                    r_dy_neg <= dy_full[CW];
                    r_rem    <= '0;
                    r_dvd    <= DVW'(dy_abs) << GB;
                    r_qcnt   <= '0;
                    r_phase  <= 2'd0;
                    if (a1 == a0) begin
                        r_grad  <= GW'(2 ** GB);
                        r_state <= S_END;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_qcnt == QW'(DVW)) begin
                        r_grad  <= r_dy_neg ? -GW'(r_dvd) : GW'(r_dvd);
                        r_state <= S_END;
                    end else begin
                        r_rem  <= qbit ? trial - {1'b0, r_dx} : trial;
                        r_dvd  <= {r_dvd[DVW-2:0], qbit};
                        r_qcnt <= r_qcnt + QW'(1);
                    end
                end
                S_END: begin
                    r_col <= ecol;
                    r_y   <= yend;
                    r_gap <= egap;
                    r_sub <= 1'b0;
                    if (r_phase == 2'd0) begin
                        r_col1   <= ecol;
                        r_intery <= yend + YW'(r_grad);
                    end else begin
                        r_col2 <= ecol;
                    end
                    r_state <= S_LVL;
                end
                S_LVL: begin
                    r_prod  <= MW'(wgt) * MW'(r_gap);
                    r_px    <= px;
                    r_py    <= py;
                    r_inf   <= inf;
                    r_state <= S_ADR;
                end
                S_ADR: begin
                    r_addr <= addr_full;
                    r_lvl  <= lvl;
                    if (!r_inf) begin
                        r_state <= (r_op == alr_pkg::OP_LINE) ? S_NEXT : S_DONE;
                    end else begin
                        priority case (r_op)
                            alr_pkg::OP_POINT: r_state <= S_PT;
                            default:           r_state <= S_RD;
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= (r_op == alr_pkg::OP_READ) ? S_RDB : S_WR;
                end
                S_RDB: begin
                    r_rval  <= r_rdata;
                    r_state <= S_DONE;
                end
                S_PT: begin
                    r_cnt   <= CNT_ONE;
                    r_state <= S_DONE;
                end
                S_WR: begin
                    if (r_cnt != alr_pkg::CNT_LIMIT) begin
                        r_cnt <= r_cnt + CNT_ONE;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (!r_sub) begin
                        r_sub   <= 1'b1;
                        r_state <= S_LVL;
                    end else begin
                        r_sub <= 1'b0;
                        priority case (r_phase)
                            2'd0: begin
                                r_phase <= 2'd1;
                                r_state <= S_END;
                            end
                            2'd1: begin
                                r_phase <= 2'd2;
                                r_col   <= r_col1 + PW'(1);
                                r_y     <= r_intery;
                                r_gap   <= FW'(2 ** FRAC_BITS);
                                r_state <= (r_col1 + PW'(1) < r_col2) ? S_LVL : S_DONE;
                            end
                            default: begin
                                r_col   <= ncol;
                                r_y     <= r_y + YW'(r_grad);
                                r_state <= (ncol < r_col2) ? S_LVL : S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    r_valid   <= 1'b1;
                    r_clr_cmd <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_read_value     = r_rval;
    assign o_pixels_touched = r_cnt;

endmodule
